// ----- src/rpb_pkg.sv -----
// Shared constants, codes and helpers for the rotated pixel blit.
`timescale 1ns / 1ps

package rpb_pkg;

    // Default composite image size
    localparam int DEFAULT_COMPOSITE_WIDTH  = 400;
    localparam int DEFAULT_COMPOSITE_HEIGHT = 480;

    // Field widths
    localparam int DIM_W        = 16;
    localparam int FMT_W        = 3;
    localparam int ROW_OFS_W    = 9;
    localparam int PIXEL_W      = 32;
    localparam int TGT_INDEX_W  = 18;
    localparam int SRC_OFFSET_W = 32;
    localparam int COLOR_W      = 32;
    localparam int BPP_W        = 3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_STRIDE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ROW_OFFSET = 3'd4;

    // Pixel format codes
    localparam logic [FMT_W-1:0] FMT_RGBA8    = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGB8     = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGBA5551 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGBA4    = 3'd4;

    // Walker decision for the current transfer
    typedef struct packed {
        logic take;   // item produces a result
        logic last;   // final pixel of the clamped area
    } walk_t;

    function automatic logic [BPP_W-1:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
        logic [BPP_W-1:0] bpp;
        case (fmt)
            FMT_RGBA8: bpp = 3'd4;
            FMT_RGB8:  bpp = 3'd3;
            default:   bpp = 3'd2;
        endcase
        return bpp;
    endfunction

endpackage

// ----- src/rpb_color.sv -----
// Source pixel format to RGBA8888 conversion.
`timescale 1ns / 1ps

module rpb_color (
    input  logic [rpb_pkg::PIXEL_W-1:0] pixel_bytes,
    input  logic [rpb_pkg::FMT_W-1:0]   pixel_format,
    output logic [rpb_pkg::COLOR_W-1:0] rgba_color
);
    import rpb_pkg::*;

    // floor(v * 255 / 31) through a reciprocal multiply; error stays below 1/31
    function automatic logic [7:0] scale5(input logic [4:0] v);
        logic [12:0] x;
        logic [28:0] p;
        x = 13'(v) * 13'd255;
        p = 29'(x) * 29'd33826;
        return p[27:20];
    endfunction

    // floor(v * 255 / 63) the same way; error stays below 1/63
    function automatic logic [7:0] scale6(input logic [5:0] v);
        logic [13:0] x;
        logic [28:0] p;
        x = 14'(v) * 14'd255;
        p = 29'(x) * 29'd16645;
        return p[27:20];
    endfunction

    function automatic logic [7:0] scale4(input logic [3:0] v);
        return {v, v};
    endfunction

    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] raw;

    assign b0  = pixel_bytes[7:0];
    assign b1  = pixel_bytes[15:8];
    assign b2  = pixel_bytes[23:16];
    assign b3  = pixel_bytes[31:24];
    assign raw = {b1, b0};

    always_comb
    begin
        case (pixel_format)
            FMT_RGBA8:    rgba_color = {b0, b1, b2, b3};
            FMT_RGB8:     rgba_color = {8'hFF, b0, b1, b2};
            FMT_RGB565:   rgba_color = {8'hFF, scale5(raw[15:11]), scale6(raw[10:5]),
                                        scale5(raw[4:0])};
            FMT_RGBA5551: rgba_color = {{8{raw[0]}}, scale5(raw[15:11]), scale5(raw[10:6]),
                                        scale5(raw[5:1])};
            FMT_RGBA4:    rgba_color = {scale4(raw[3:0]), scale4(raw[15:12]),
                                        scale4(raw[11:8]), scale4(raw[7:4])};
            default:      rgba_color = 32'hFF00_0000;
        endcase
    end

endmodule

// ----- src/rpb_walker.sv -----
// Clamped area geometry and destination row/column counters.
`timescale 1ns / 1ps

module rpb_walker #(
    parameter int COMPOSITE_WIDTH  = rpb_pkg::DEFAULT_COMPOSITE_WIDTH,
    parameter int COMPOSITE_HEIGHT = rpb_pkg::DEFAULT_COMPOSITE_HEIGHT,
    parameter int COL_W            = $clog2(COMPOSITE_WIDTH + 1),
    parameter int ROW_W            = $clog2(COMPOSITE_HEIGHT + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [rpb_pkg::DIM_W-1:0]     source_width,
    input  logic [rpb_pkg::DIM_W-1:0]     source_height,
    input  logic [rpb_pkg::DIM_W-1:0]     source_stride,
    input  logic [rpb_pkg::FMT_W-1:0]     pixel_format,
    input  logic [rpb_pkg::ROW_OFS_W-1:0] target_row_offset,
    output rpb_pkg::walk_t               walk,
    output logic [ROW_W-1:0]             row,
    output logic [COL_W-1:0]             col,
    output logic [COL_W-1:0]             xoff
);
    import rpb_pkg::*;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic [BPP_W-1:0] bpp;
    logic [17:0]      min_stride;
    logic             geom_ok;
    logic [16:0]      cw_wide, ch_room, ch_wide;
    logic [COL_W-1:0] cw;
    logic [ROW_W-1:0] ch;
    logic             wrap, col_end, row_end;

    assign bpp        = bytes_per_pixel(pixel_format);
    assign min_stride = 18'(source_width) * 18'(bpp);
    assign geom_ok    = (source_width != '0) && (source_height != '0)
                        && (18'(source_stride) >= min_stride)
                        && (32'(target_row_offset) < 32'(COMPOSITE_HEIGHT));

    assign cw_wide = (17'(source_height) < 17'(COMPOSITE_WIDTH))
                     ? 17'(source_height) : 17'(COMPOSITE_WIDTH);
    assign ch_room = 17'(COMPOSITE_HEIGHT) - 17'(target_row_offset);
    assign ch_wide = (17'(source_width) < ch_room) ? 17'(source_width) : ch_room;
    assign cw      = cw_wide[COL_W-1:0];
    assign ch      = ch_wide[ROW_W-1:0];
    assign xoff    = COL_W'((COL_W + 1)'(COMPOSITE_WIDTH) - (COL_W + 1)'(cw)) >> 1;

    // Restart at the origin when a register change left the counters outside
    assign wrap    = (row_reg >= ch) || (col_reg >= cw);
    assign row     = wrap ? '0 : row_reg;
    assign col     = wrap ? '0 : col_reg;
    assign col_end = (COL_W'(col + 1'b1) == cw);
    assign row_end = (ROW_W'(row + 1'b1) == ch);

    assign walk.take = geom_ok;
    assign walk.last = col_end && row_end;

    always_comb
    begin
        col_next = col_end ? '0 : COL_W'(col + 1'b1);
        if (col_end)
        begin
            row_next = row_end ? '0 : ROW_W'(row + 1'b1);
        end
        else
        begin
            row_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (step && geom_ok)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// ----- src/rotated_pixel_blit_to_rgba8888.sv -----
// Top level of the rotated pixel blit: configuration, input and result registers.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-----------------------------------------------
//  input    | in_valid  | in_stall  | pixel_bytes
//  result   | out_valid | out_stall | target_index, source_offset, rgba_color,
//           |           |           | last_pixel
//  config   | cfg_write | -         | cfg_index, cfg_data
//
// One pixel per clock while in_stall is low. An item passes the input register and then the
// result register: the walker decision lands in the input register, the address multiply
// and colour conversion land in the result register. in_stall rises only when both registers
// hold data and out_stall is high. Reset clears counters and valid flags and loads the
// default geometry; items that produce no result are dropped on transfer.
`timescale 1ns / 1ps

module rotated_pixel_blit_to_rgba8888 #(
    parameter int COMPOSITE_WIDTH  = rpb_pkg::DEFAULT_COMPOSITE_WIDTH,
    parameter int COMPOSITE_HEIGHT = rpb_pkg::DEFAULT_COMPOSITE_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rpb_pkg::DIM_W-1:0]         cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rpb_pkg::PIXEL_W-1:0]       pixel_bytes,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rpb_pkg::TGT_INDEX_W-1:0]   target_index,
    output logic [rpb_pkg::SRC_OFFSET_W-1:0]  source_offset,
    output logic [rpb_pkg::COLOR_W-1:0]       rgba_color,
    output logic                             last_pixel
);
    import rpb_pkg::*;

    localparam int COL_W = $clog2(COMPOSITE_WIDTH + 1);
    localparam int ROW_W = $clog2(COMPOSITE_HEIGHT + 1);

    // Configuration registers
    logic [DIM_W-1:0]     source_width_reg;
    logic [DIM_W-1:0]     source_height_reg;
    logic [DIM_W-1:0]     source_stride_reg;
    logic [FMT_W-1:0]     pixel_format_reg;
    logic [ROW_OFS_W-1:0] target_row_offset_reg;

    // Input register
    logic                 s1_valid_reg, s1_valid_next;
    logic [PIXEL_W-1:0]   s1_pixel_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic [COL_W-1:0]     s1_xoff_reg;
    logic                 s1_last_reg;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    logic [TGT_INDEX_W-1:0]  target_index_reg;
    logic [SRC_OFFSET_W-1:0] source_offset_reg;
    logic [COLOR_W-1:0]      rgba_color_reg;
    logic                    last_pixel_reg;

    walk_t            walk;
    logic [ROW_W-1:0] walk_row;
    logic [COL_W-1:0] walk_col;
    logic [COL_W-1:0] walk_xoff;

    logic             in_xfer, load_s1, out_free;
    logic [DIM_W-1:0] src_y;
    logic [31:0]      row_bytes, offset_sum, row_abs, index_sum;
    logic [COLOR_W-1:0] color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg      <= 16'd240;
            source_height_reg     <= 16'd400;
            source_stride_reg     <= 16'd960;
            pixel_format_reg      <= FMT_RGBA8;
            target_row_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:      source_width_reg      <= cfg_data;
                REG_SOURCE_HEIGHT:     source_height_reg     <= cfg_data;
                REG_SOURCE_STRIDE:     source_stride_reg     <= cfg_data;
                REG_PIXEL_FORMAT:      pixel_format_reg      <= cfg_data[FMT_W-1:0];
                REG_TARGET_ROW_OFFSET: target_row_offset_reg <= cfg_data[ROW_OFS_W-1:0];
                default: ;
            endcase
        end
    end

    rpb_walker #(
        .COMPOSITE_WIDTH  (COMPOSITE_WIDTH),
        .COMPOSITE_HEIGHT (COMPOSITE_HEIGHT),
        .COL_W            (COL_W),
        .ROW_W            (ROW_W)
    ) u_walker (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (in_xfer),
        .source_width      (source_width_reg),
        .source_height     (source_height_reg),
        .source_stride     (source_stride_reg),
        .pixel_format      (pixel_format_reg),
        .target_row_offset (target_row_offset_reg),
        .walk              (walk),
        .row               (walk_row),
        .col               (walk_col),
        .xoff              (walk_xoff)
    );

    // Handshake: the input register moves whenever the result register is free
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;
    assign load_s1  = in_xfer && walk.take;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load_s1)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_pixel_reg <= pixel_bytes;
            s1_row_reg   <= walk_row;
            s1_col_reg   <= walk_col;
            s1_xoff_reg  <= walk_xoff;
            s1_last_reg  <= walk.last;
        end
    end

    // Rotation: composite column x reads source row (height - 1 - x)
    assign src_y      = source_height_reg - 16'd1 - 16'(s1_col_reg);
    assign row_bytes  = 32'(s1_row_reg) * 32'(bytes_per_pixel(pixel_format_reg));
    assign offset_sum = 32'(src_y) * 32'(source_stride_reg) + row_bytes;
    assign row_abs    = 32'(target_row_offset_reg) + 32'(s1_row_reg);
    assign index_sum  = row_abs * 32'(COMPOSITE_WIDTH) + 32'(s1_xoff_reg) + 32'(s1_col_reg);

    rpb_color u_color (
        .pixel_bytes  (s1_pixel_reg),
        .pixel_format (pixel_format_reg),
        .rgba_color   (color)
    );

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            target_index_reg  <= index_sum[TGT_INDEX_W-1:0];
            source_offset_reg <= offset_sum;
            rgba_color_reg    <= color;
            last_pixel_reg    <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign target_index  = target_index_reg;
    assign source_offset = source_offset_reg;
    assign rgba_color    = rgba_color_reg;
    assign last_pixel    = last_pixel_reg;

    // A stall on the input means both registers are full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free register");

    // A transfer that produces a result occupies the input register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        load_s1 |=> s1_valid_reg)
        else $error("accepted pixel lost before the input register");

    // A held item in the input register is not overwritten while the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall)
        |=> (s1_valid_reg && $stable(s1_row_reg) && $stable(s1_col_reg)))
        else $error("input register changed while blocked");

    // The result register only fills from an occupied input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result appeared without a source item");

endmodule
